/* sv/multi_code_lock_controller_macros.svh */
`ifndef MULTI_CODE_LOCK_CONTROLLER_MACROS_SVH
`define MULTI_CODE_LOCK_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcl assertion failed");

// next-cycle implication, disabled in reset
`define MCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcl assertion failed");

`endif

/* sv/mcl_pkg.sv */
`timescale 1ns / 1ps

package mcl_pkg;

   localparam int ACTION_BITS  = 3;
   localparam int CODE_IN_BITS = 32;
   localparam int STATUS_BITS  = 2;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_CODE_BITS   = 32;

   // action codes
   localparam logic [ACTION_BITS-1:0] ACT_TOGGLE     = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_REGISTER   = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_UNREGISTER = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_REPLACE    = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_UNLOCK     = 3'd4;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_WRONG_MODE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL       = 2'd3;

   // table update request
   typedef struct packed {
      logic add;
      logic drop;
      logic load;
   } tbl_cmd_type;

   // table lookup result
   typedef struct packed {
      logic hit;
      logic full;
   } tbl_stat_type;

endpackage

/* sv/mcl_code_table.sv */
`timescale 1ns / 1ps
`include "multi_code_lock_controller_macros.svh"

module mcl_code_table
   import mcl_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int CODE_BITS   = DEF_CODE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CODE_BITS-1:0] code,
   input  tbl_cmd_type          cmd,
   input  logic                 csr_load,
   input  logic [CODE_BITS-1:0] csr_code,
   output tbl_stat_type         stat
);

   localparam logic [TABLE_DEPTH-1:0] ONLY_FIRST = TABLE_DEPTH'(1);

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] valid_in;
   logic [CODE_BITS-1:0]   entry_ff [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] match;
   logic [TABLE_DEPTH-1:0] free;
   logic [TABLE_DEPTH-1:0] first_free;
   logic                   load_any;
   logic [CODE_BITS-1:0]   wr_data;

   // parallel compare against every valid entry
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = valid_ff[i] && (entry_ff[i] == code);
      end
   end

   // lowest free entry, one-hot
   assign free       = ~valid_ff;
   assign first_free = free & (~free + ONLY_FIRST);

   assign stat.hit  = |match;
   assign stat.full = ~|free;

   assign load_any = csr_load || cmd.load;

   always_comb begin
      priority if (load_any) begin
         valid_in = ONLY_FIRST;
      end else if (cmd.add) begin
         valid_in = valid_ff | first_free;
      end else if (cmd.drop) begin
         valid_in = valid_ff & ~match;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= ONLY_FIRST;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry zero takes zero on reset, the initial code's reset value
   assign wr_data = reset ? '0 : (csr_load ? csr_code : code);

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (((reset || load_any) && (i == 0)) || (!reset && cmd.add && first_free[i])) begin
            entry_ff[i] <= wr_data;
         end
      end
   end

   // codes stay distinct, so at most one entry matches
   `MCL_ASSERT_NOW(a_single_match, clock, reset, 1'b1, $onehot0(match))

endmodule

/* sv/mcl_action_unit.sv */
`timescale 1ns / 1ps

module mcl_action_unit
   import mcl_pkg::*;
(
   input  logic [ACTION_BITS-1:0] action,
   input  logic                   mode,
   input  tbl_stat_type           stat,
   output logic                   granted,
   output logic [STATUS_BITS-1:0] status,
   output logic                   mode_next,
   output tbl_cmd_type            cmd
);

   always_comb begin
      granted   = 1'b0;
      status    = ST_OK;
      mode_next = mode;
      cmd       = '0;
      unique case (action)
         ACT_TOGGLE: begin
            if (stat.hit) begin
               mode_next = !mode;
               granted   = 1'b1;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         ACT_REGISTER: begin
            if (!mode) begin
               status = ST_WRONG_MODE;
            end else if (!stat.hit) begin
               if (stat.full) begin
                  status = ST_FULL;
               end else begin
                  cmd.add = 1'b1;
               end
            end
         end
         ACT_UNREGISTER: begin
            if (!mode) begin
               status = ST_WRONG_MODE;
            end else begin
               cmd.drop = stat.hit;
            end
         end
         ACT_REPLACE: begin
            if (!mode) begin
               status = ST_WRONG_MODE;
            end else begin
               cmd.load = 1'b1;
            end
         end
         ACT_UNLOCK: begin
            if (mode) begin
               status = ST_WRONG_MODE;
            end else if (stat.hit) begin
               granted = 1'b1;
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         default: begin
            // unused actions: no effect
         end
      endcase
   end

endmodule

/* sv/multi_code_lock_controller.sv */
`timescale 1ns / 1ps
// Multi-code keypad lock controller. Each request word carries an action (toggle mode,
// register, unregister, replace all, try unlock) and a code; each one yields exactly one
// response word with granted, status and the mode after the action. Codes are kept in a
// table of TABLE_DEPTH distinct entries, compared on their low CODE_BITS bits. Throughput
// is one word per clock while responses drain; a word sits in the request register, then
// the single pass compares the code against every table entry at once and writes the
// response register, so the table compare sets the cycle. After reset the lock is in
// programming mode with code zero as the only entry, with no clearing pass. Writing
// csr_initial_code (only while idle) reloads the table with that code alone and returns
// to programming mode.
`include "multi_code_lock_controller_macros.svh"

module multi_code_lock_controller
   import mcl_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int CODE_BITS   = DEF_CODE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_BITS-1:0]  req_action,
   input  logic [CODE_IN_BITS-1:0] req_code,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_granted,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic                    rsp_in_programming,
   // configuration
   input  logic                    csr_write_enable,
   input  logic [CODE_IN_BITS-1:0] csr_initial_code
);

   // request register
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [ACTION_BITS-1:0]  s1_action_ff;
   logic [CODE_IN_BITS-1:0] s1_code_ff;
   logic                    s1_fire;

   // lock mode, 1 = programming
   logic mode_ff;
   logic mode_in;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   granted_ff;
   logic [STATUS_BITS-1:0] status_ff;
   logic                   prog_ff;

   // decision outputs
   logic                   granted_calc;
   logic [STATUS_BITS-1:0] status_calc;
   logic                   mode_calc;
   tbl_cmd_type            cmd_calc;
   tbl_cmd_type            tbl_cmd;
   tbl_stat_type           tbl_stat;

   logic [CODE_BITS-1:0] look_code;
   logic [CODE_BITS-1:0] csr_code;

   // the word in the request register moves on when the response slot is free or drains
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);

   // codes are kept on their low CODE_BITS bits
   assign look_code = CODE_BITS'(s1_code_ff);
   assign csr_code  = CODE_BITS'(csr_initial_code);

   mcl_code_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CODE_BITS   (CODE_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .code     (look_code),
      .cmd      (tbl_cmd),
      .csr_load (csr_write_enable),
      .csr_code (csr_code),
      .stat     (tbl_stat)
   );

   mcl_action_unit u_action (
      .action    (s1_action_ff),
      .mode      (mode_ff),
      .stat      (tbl_stat),
      .granted   (granted_calc),
      .status    (status_calc),
      .mode_next (mode_calc),
      .cmd       (cmd_calc)
   );

   // table changes only when the word actually completes
   assign tbl_cmd = s1_fire ? cmd_calc : '0;

   always_comb begin
      priority if (csr_write_enable) begin
         mode_in = 1'b1;
      end else if (s1_fire) begin
         mode_in = mode_calc;
      end else begin
         mode_in = mode_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_action_ff <= req_action;
         s1_code_ff   <= req_code;
      end
      if (s1_fire) begin
         granted_ff <= granted_calc;
         status_ff  <= status_calc;
         prog_ff    <= mode_calc;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = granted_ff;
   assign rsp_status         = status_ff;
   assign rsp_in_programming = prog_ff;

   // a granted word always reports ok
   `MCL_ASSERT_NOW(a_granted_ok, clock, reset, rsp_valid_ff && granted_ff, status_ff == ST_OK)

   // a held request keeps its word
   `MCL_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_code_ff) && $stable(s1_action_ff))

   // a configuration write always returns to programming mode
   `MCL_ASSERT_NEXT(a_csr_mode, clock, reset, csr_write_enable, mode_ff)

endmodule

/* tb/sv/tb_multi_code_lock_controller.sv */
`timescale 1ns / 1ps

module tb_multi_code_lock_controller;
   import mcl_pkg::*;

   localparam int LOCK_DEPTH    = DEF_TABLE_DEPTH;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 100;
   localparam int NUM_PHASES    = 8;
   localparam int POOL_SIZE     = 24;
   localparam int POOL_IDX_BITS = $clog2(POOL_SIZE);
   localparam int SETTLE_CYCLES = 4;

   // action codes the block treats as no-ops
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                   granted;
      logic [STATUS_BITS-1:0] status;
      logic                   in_programming;
   } lock_response_type;

   // one line of the directed script; pinned rows carry a hand-written response
   typedef struct {
      logic [ACTION_BITS-1:0]  action;
      logic [CODE_IN_BITS-1:0] code;
      bit                      pinned;
      lock_response_type       want;
   } script_row_type;

   logic                    clock;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_ready;
   logic [ACTION_BITS-1:0]  req_action       = ACT_TOGGLE;
   logic [CODE_IN_BITS-1:0] req_code         = '0;
   logic                    rsp_valid;
   logic                    rsp_ready        = 1'b0;
   logic                    rsp_granted;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic                    rsp_in_programming;
   logic                    csr_write_enable = 1'b0;
   logic [CODE_IN_BITS-1:0] csr_initial_code = '0;

   // side-band that travels with the request word, seen only by the checker
   bit                      word_pinned      = 1'b0;
   lock_response_type       word_pinned_want = '0;

   multi_code_lock_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_code           (req_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_granted        (rsp_granted),
      .rsp_status         (rsp_status),
      .rsp_in_programming (rsp_in_programming),
      .csr_write_enable   (csr_write_enable),
      .csr_initial_code   (csr_initial_code)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // lock model: code table, valid bits and mode
   // ---------------------------------------------------------------
   logic [CODE_IN_BITS-1:0] lock_codes [LOCK_DEPTH];
   bit                      lock_used  [LOCK_DEPTH];
   bit                      lock_prog;

   // table cleared, given code alone in entry zero, back to programming mode
   function automatic void load_lock(input logic [CODE_IN_BITS-1:0] code);
      int i;
      for (i = 0; i < LOCK_DEPTH; i++) begin
         lock_codes[i] = '0;
         lock_used[i]  = 1'b0;
      end
      lock_codes[0] = code;
      lock_used[0]  = 1'b1;
      lock_prog     = 1'b1;
   endfunction

   // apply one request word to the model and return the response it gives
   function automatic lock_response_type predict_lock_response(
      input logic [ACTION_BITS-1:0]  action,
      input logic [CODE_IN_BITS-1:0] code
   );
      lock_response_type r;
      int                hit;
      int                free_slot;
      int                i;
      r         = '0;
      hit       = -1;
      free_slot = -1;
      for (i = 0; i < LOCK_DEPTH; i++) begin
         if (hit < 0 && lock_used[i] && lock_codes[i] == code) hit = i;
         if (free_slot < 0 && !lock_used[i]) free_slot = i;
      end
      case (action)
         ACT_TOGGLE: begin
            if (hit >= 0) begin
               lock_prog = !lock_prog;
               r.granted = 1'b1;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         ACT_REGISTER: begin
            if (!lock_prog) begin
               r.status = ST_WRONG_MODE;
            end else if (hit < 0) begin
               // lowest free entry takes it; no free entry means a full table
               if (free_slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  lock_codes[free_slot] = code;
                  lock_used[free_slot]  = 1'b1;
               end
            end
         end
         ACT_UNREGISTER: begin
            // an absent code is dropped silently
            if (!lock_prog) r.status = ST_WRONG_MODE;
            else if (hit >= 0) lock_used[hit] = 1'b0;
         end
         ACT_REPLACE: begin
            if (!lock_prog) r.status = ST_WRONG_MODE;
            else load_lock(code);
         end
         ACT_UNLOCK: begin
            if (lock_prog) r.status = ST_WRONG_MODE;
            else if (hit >= 0) r.granted = 1'b1;
            else r.status = ST_NOT_FOUND;
         end
         default: begin
         end
      endcase
      r.in_programming = lock_prog;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------
   lock_response_type pending_responses [$];
   int mismatches      = 0;
   int words_checked   = 0;
   int grants_seen     = 0;
   int wrong_mode_seen = 0;
   int not_found_seen  = 0;
   int full_seen       = 0;
   int config_writes   = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // accepted request words go through the model first, then any response word
   // accepted at the same edge is matched against the oldest expectation
   always @(posedge clock) begin
      lock_response_type predicted;
      lock_response_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = predict_lock_response(req_action, req_code);
            pending_responses.push_back(word_pinned ? word_pinned_want : predicted);
            if (predicted.granted) grants_seen++;
            case (predicted.status)
               ST_WRONG_MODE: wrong_mode_seen++;
               ST_NOT_FOUND:  not_found_seen++;
               ST_FULL:       full_seen++;
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response word with none pending", 1, 0);
            end else begin
               want = pending_responses.pop_front();
               words_checked++;
               if (rsp_granted !== want.granted)
                  report_mismatch("granted", rsp_granted, want.granted);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_in_programming !== want.in_programming)
                  report_mismatch("in_programming", rsp_in_programming,
                                  want.in_programming);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // idling knobs, receiver stalls
   // ---------------------------------------------------------------
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // global watchdog
   int cycle_count = 0;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses still pending",
               cycle_count, pending_responses.size());
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   logic [CODE_IN_BITS-1:0] code_pool [POOL_SIZE];

   // present one request word, after a random gap, and hold it until taken
   task automatic send_request(
      input logic [ACTION_BITS-1:0]  action,
      input logic [CODE_IN_BITS-1:0] code,
      input bit                      pinned,
      input lock_response_type       want
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_code         <= code;
      word_pinned      <= pinned;
      word_pinned_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and let the pipeline empty out
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write, only ever issued with the block idle
   task automatic write_initial_code(input logic [CODE_IN_BITS-1:0] code);
      csr_write_enable <= 1'b1;
      csr_initial_code <= code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      load_lock(code);
      config_writes++;
   endtask

   // codes the random part draws from: the fresh initial code plus a mix of small
   // values, full-range values, complements and one-bit neighbors
   function automatic void refill_code_pool(input logic [CODE_IN_BITS-1:0] first_code);
      int i;
      code_pool[0] = first_code;
      for (i = 1; i < POOL_SIZE; i++) begin
         case ($urandom_range(3))
            0:       code_pool[i] = $urandom_range(15);
            1:       code_pool[i] = ~code_pool[i-1];
            2:       code_pool[i] = $urandom();
            default: code_pool[i] = code_pool[i-1] ^ (32'd1 << $urandom_range(31));
         endcase
      end
   endfunction

   // one random request word; returns 1 when it is a real action
   task automatic issue_random_request(output bit counted);
      logic [ACTION_BITS-1:0]  action;
      logic [CODE_IN_BITS-1:0] code;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 28)      action = ACT_REGISTER;
      else if (pick < 44) action = ACT_TOGGLE;
      else if (pick < 70) action = ACT_UNLOCK;
      else if (pick < 84) action = ACT_UNREGISTER;
      else if (pick < 89) action = ACT_REPLACE;
      else if (pick < 93) action = ACTION_BITS'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      else                action = ACTION_BITS'($urandom_range(ACT_SPARE_HI));
      pick = $urandom_range(99);
      if (pick < 75)      code = code_pool[POOL_IDX_BITS'($urandom_range(POOL_SIZE - 1))];
      else if (pick < 85) code = code_pool[POOL_IDX_BITS'($urandom_range(POOL_SIZE - 1))]
                                 ^ (32'd1 << $urandom_range(31));
      else if (pick < 90) code = $urandom_range(1) ? '1 : '0;
      else                code = $urandom();
      send_request(action, code, 1'b0, '0);
      counted = (action <= ACT_UNLOCK);
   endtask

   function automatic script_row_type row(
      input logic [ACTION_BITS-1:0]  action,
      input logic [CODE_IN_BITS-1:0] code,
      input bit                      pinned,
      input logic                    granted,
      input logic [STATUS_BITS-1:0]  status,
      input logic                    in_programming
   );
      script_row_type r;
      r.action              = action;
      r.code                = code;
      r.pinned              = pinned;
      r.want.granted        = granted;
      r.want.status         = status;
      r.want.in_programming = in_programming;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   script_row_type lock_script [$];
   logic [CODE_IN_BITS-1:0] boot_code;
   bit counted;
   int phase_words;
   int p;
   int i;

   initial begin
      // model starts where reset leaves the block: code zero alone, programming
      load_lock('0);

      // directed script, starting from the reset state
      lock_script.push_back(row(ACT_UNLOCK,   32'h0,     1'b1, 1'b0, ST_WRONG_MODE, 1'b1));
      lock_script.push_back(row(ACT_REGISTER, 32'h0,     1'b1, 1'b0, ST_OK,         1'b1));
      lock_script.push_back(row(ACT_TOGGLE,   32'h5,     1'b1, 1'b0, ST_NOT_FOUND,  1'b1));
      lock_script.push_back(row(ACT_UNREGISTER, 32'h5,   1'b1, 1'b0, ST_OK,         1'b1));
      lock_script.push_back(row(ACT_REGISTER, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK,     1'b1));
      // fill the rest of the table
      for (i = 1; i < LOCK_DEPTH - 1; i++)
         lock_script.push_back(row(ACT_REGISTER, CODE_IN_BITS'(i), 1'b0, 1'b0, ST_OK, 1'b1));
      lock_script.push_back(row(ACT_REGISTER, 32'hAA,    1'b1, 1'b0, ST_FULL,       1'b1));
      lock_script.push_back(row(ACT_TOGGLE,   32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK,     1'b0));
      lock_script.push_back(row(ACT_REGISTER, 32'h7,     1'b1, 1'b0, ST_WRONG_MODE, 1'b0));
      lock_script.push_back(row(ACT_UNLOCK,   32'hE,     1'b0, 1'b0, ST_OK,         1'b0));
      lock_script.push_back(row(ACT_UNLOCK,   32'hF,     1'b1, 1'b0, ST_NOT_FOUND,  1'b0));
      lock_script.push_back(row(ACT_SPARE_HI, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK,     1'b0));
      lock_script.push_back(row(ACT_REPLACE,  32'h0,     1'b1, 1'b0, ST_WRONG_MODE, 1'b0));
      lock_script.push_back(row(ACT_TOGGLE,   32'h0,     1'b1, 1'b1, ST_OK,         1'b1));
      lock_script.push_back(row(ACT_REPLACE,  32'h5A5A_A5A5, 1'b1, 1'b0, ST_OK,     1'b1));
      lock_script.push_back(row(ACT_TOGGLE,   32'hFFFF_FFFF, 1'b1, 1'b0, ST_NOT_FOUND, 1'b1));
      lock_script.push_back(row(ACT_SPARE_LO, 32'h0,     1'b1, 1'b0, ST_OK,         1'b1));
      lock_script.push_back(row(ACT_UNREGISTER, 32'h5A5A_A5A5, 1'b0, 1'b0, ST_OK,   1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (lock_script[k])
         send_request(lock_script[k].action, lock_script[k].code,
                      lock_script[k].pinned, lock_script[k].want);
      wait_for_quiet();

      // random phases, each under a fresh initial code and one of four idle patterns
      for (p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         case (p)
            0:       boot_code = 32'hFFFF_FFFF;
            1:       boot_code = 32'h0000_0000;
            3:       boot_code = 32'h8000_0000;
            4:       boot_code = 32'h0000_0001;
            6:       boot_code = 32'h7FFF_FFFF;
            default: boot_code = $urandom();
         endcase
         write_initial_code(boot_code);
         refill_code_pool(boot_code);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            issue_random_request(counted);
            if (counted) phase_words++;
         end
         wait_for_quiet();
      end

      while (pending_responses.size() != 0) begin
         report_mismatch("response never delivered", 0, 1);
         void'(pending_responses.pop_front());
      end

      $display("checked %0d response words: %0d granted, %0d wrong mode, %0d not found,",
               words_checked, grants_seen, wrong_mode_seen, not_found_seen);
      $display("%0d table full; initial code written %0d times under 4 idle patterns",
               full_seen, config_writes);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end

endmodule
